// ===== hdl/olt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and constants for the ordered list table: field widths, command
// and status codes, cell controls and the sequencer states.
// ----------------------------------------------------------------------------
package olt_pkg;

   // list capacity and derived widths
   localparam int DEPTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // transaction field widths
   localparam int CMD_W    = 3;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 5;
   localparam int COUNT_W  = 6;

   // wide enough for position versus count + 1
   localparam int CMP_W = CNT_W + POS_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_POS    = 3'd0,
      CMD_INS_AFTER  = 3'd1,
      CMD_INS_BEFORE = 3'd2,
      CMD_DEL_POS    = 3'd3,
      CMD_DEL_AFTER  = 3'd4,
      CMD_DEL_BEFORE = 3'd5,
      CMD_READ_FWD   = 3'd6,
      CMD_READ_REV   = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_BADPOS = 3'd2,
      ST_NOKEY  = 3'd3,
      ST_NONB   = 3'd4,
      ST_FULL   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_NEW,
      CELL_LEFT,
      CELL_RIGHT
   } cell_op_type;

   typedef enum logic [1:0] {
      EDIT_NONE,
      EDIT_INS,
      EDIT_DEL
   } edit_op_type;

   typedef struct packed {
      edit_op_type      op;
      logic [IDX_W-1:0] idx;
   } edit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_DECIDE,
      ST_READ
   } state_type;

endpackage

// ===== hdl/olt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_if
// Valid/ready channels of the ordered list table: command channel and
// response channel.
// ----------------------------------------------------------------------------
interface olt_req_if;
   logic                                      valid;
   logic                                      ready;
   logic        [olt_pkg::CMD_W-1:0]          cmd;
   logic        [olt_pkg::POS_W-1:0]          position;
   logic signed [olt_pkg::DATA_W-1:0]         key;
   logic signed [olt_pkg::DATA_W-1:0]         value;

   modport source (output valid, output cmd, output position, output key, output value,
                   input ready);
   modport sink   (input valid, input cmd, input position, input key, input value,
                   output ready);
endinterface

interface olt_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic        [olt_pkg::STATUS_W-1:0]       status;
   logic signed [olt_pkg::DATA_W-1:0]         data;
   logic        [olt_pkg::INDEX_W-1:0]        index;
   logic        [olt_pkg::COUNT_W-1:0]        count;
   logic                                      last;

   modport source (output valid, output status, output data, output index, output count,
                   output last, input ready);
   modport sink   (input valid, input status, input data, input index, input count,
                   input last, output ready);
endinterface

// ===== hdl/olt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olt_cell
// One list slot: holds an entry, shifts in from either neighbor or loads a
// new value, and flags a key match.
// ----------------------------------------------------------------------------
module olt_cell (
   input  logic                                 clock,
   input  olt_pkg::cell_op_type                 op,
   input  logic signed [olt_pkg::DATA_W-1:0]    left_data,
   input  logic signed [olt_pkg::DATA_W-1:0]    right_data,
   input  logic signed [olt_pkg::DATA_W-1:0]    new_value,
   input  logic signed [olt_pkg::DATA_W-1:0]    key,
   output logic signed [olt_pkg::DATA_W-1:0]    data,
   output logic                                 hit
);

   logic signed [olt_pkg::DATA_W-1:0] data_ff;
   logic signed [olt_pkg::DATA_W-1:0] data_in;

   always_comb begin
      case (op)
         olt_pkg::CELL_NEW:   data_in = new_value;
         olt_pkg::CELL_LEFT:  data_in = left_data;
         olt_pkg::CELL_RIGHT: data_in = right_data;
         default:             data_in = data_ff;
      endcase
   end

   // entry storage: contents are meaningless until written
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign hit  = (data_ff == key);

endmodule

// ===== hdl/ordered_list_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_table_core
// Bounded ordered list of signed values kept in a row of shifting cells.
// Positional and key-relative insert/delete, forward and reverse readout.
//
//   channel   dir  handshake            payload
//   req_chan  in   valid/ready          cmd, position, key, value
//   rsp_chan  out  valid/ready          status, data, index, count, last
//
// Edit: accept, match (every cell compares the key), decide and shift; the
// response is loaded in the decide step, in the same cycle as the shift.
// Read: accept, then one response per entry (a single one on an empty list).
// One command in flight; req ready is high only in idle. A stalled response
// holds the sequencer where it is. Synchronous reset empties the list.
// ----------------------------------------------------------------------------
module ordered_list_table_core (
   input  logic        clock,
   input  logic        reset,
   olt_req_if.sink     req_chan,
   olt_rsp_if.source   rsp_chan
);

   localparam int DEPTH = olt_pkg::DEPTH;
   localparam int IDX_W = olt_pkg::IDX_W;
   localparam int CNT_W = olt_pkg::CNT_W;
   localparam int CMP_W = olt_pkg::CMP_W;

   olt_pkg::state_type                   state_ff, state_in;
   olt_pkg::cmd_type                     cmd_ff, cmd_in;
   logic        [olt_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic signed [olt_pkg::DATA_W-1:0]    key_ff, key_in;
   logic signed [olt_pkg::DATA_W-1:0]    value_ff, value_in;
   logic        [CNT_W-1:0]              count_ff, count_in;
   logic        [IDX_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic                                 head_hit_ff, head_hit_in;
   logic                                 tail_hit_ff, tail_hit_in;
   logic        [DEPTH-1:0]              mid_hit_ff, mid_hit_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   olt_pkg::status_type                  status_ff, status_in;
   logic signed [olt_pkg::DATA_W-1:0]    data_ff, data_in;
   logic        [olt_pkg::INDEX_W-1:0]   index_ff, index_in;
   logic        [olt_pkg::COUNT_W-1:0]   rcount_ff, rcount_in;
   logic                                 last_ff, last_in;

   logic signed [olt_pkg::DATA_W-1:0]    cell_data [DEPTH];
   logic        [DEPTH-1:0]              cell_hit;
   olt_pkg::cell_op_type                 cell_op   [DEPTH];
   logic        [DEPTH-1:0]              tail_sel;
   logic        [DEPTH-1:0]              mid_range;

   olt_pkg::edit_type                    edit;
   olt_pkg::status_type                  dec_status;
   logic        [CNT_W-1:0]              dec_count;

   logic                                 req_fire;
   logic                                 rsp_load;
   logic                                 list_empty;
   logic                                 list_full;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign rsp_load   = !rsp_valid_ff || rsp_chan.ready;
   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == CNT_W'(DEPTH));

   // ---------------------------------------------------------------- cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [olt_pkg::DATA_W-1:0] left_d;
      logic signed [olt_pkg::DATA_W-1:0] right_d;

      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_left
         assign left_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign right_d = '0;
      end else begin : g_right
         assign right_d = cell_data[i+1];
      end

      always_comb begin
         case (edit.op)
            olt_pkg::EDIT_INS: begin
               if (IDX_W'(i) == edit.idx)     cell_op[i] = olt_pkg::CELL_NEW;
               else if (IDX_W'(i) > edit.idx) cell_op[i] = olt_pkg::CELL_LEFT;
               else                           cell_op[i] = olt_pkg::CELL_HOLD;
            end
            olt_pkg::EDIT_DEL: begin
               if (IDX_W'(i) >= edit.idx) cell_op[i] = olt_pkg::CELL_RIGHT;
               else                       cell_op[i] = olt_pkg::CELL_HOLD;
            end
            default: cell_op[i] = olt_pkg::CELL_HOLD;
         endcase
      end

      // tail slot and the interior slots searched after head and tail
      assign tail_sel[i]  = (CNT_W'(i + 1) == count_ff);
      assign mid_range[i] = (i >= 1) && (CNT_W'(i + 1) < count_ff);

      olt_cell u_cell (
         .clock      (clock),
         .op         (cell_op[i]),
         .left_data  (left_d),
         .right_data (right_d),
         .new_value  (value_ff),
         .key        (key_ff),
         .data       (cell_data[i]),
         .hit        (cell_hit[i])
      );
   end

   // ---------------------------------------------------------------- decide
   always_comb begin
      logic [CNT_W-1:0] m;
      logic             found;
      logic [CMP_W-1:0] pos_x;
      logic [CMP_W-1:0] cnt_x;
      logic [CNT_W-1:0] tgt;

      m     = '0;
      found = head_hit_ff || tail_hit_ff || (|mid_hit_ff);
      pos_x = CMP_W'(pos_ff);
      cnt_x = CMP_W'(count_ff);
      tgt   = '0;

      if (head_hit_ff) begin
         m = '0;
      end else if (tail_hit_ff) begin
         m = count_ff - CNT_W'(1);
      end else begin
         for (int i = DEPTH - 1; i >= 1; i--) begin
            if (mid_hit_ff[i]) m = CNT_W'(i);
         end
      end

      dec_status = olt_pkg::ST_OK;
      edit.op    = olt_pkg::EDIT_NONE;

      case (cmd_ff)
         olt_pkg::CMD_INS_POS: begin
            tgt = CNT_W'(pos_x - CMP_W'(1));
            if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) dec_status = olt_pkg::ST_BADPOS;
            else if (list_full)                           dec_status = olt_pkg::ST_FULL;
            else                                          edit.op    = olt_pkg::EDIT_INS;
         end
         olt_pkg::CMD_DEL_POS: begin
            tgt = CNT_W'(pos_x - CMP_W'(1));
            if (list_empty)                         dec_status = olt_pkg::ST_EMPTY;
            else if (pos_x == '0 || pos_x > cnt_x)  dec_status = olt_pkg::ST_BADPOS;
            else                                    edit.op    = olt_pkg::EDIT_DEL;
         end
         olt_pkg::CMD_INS_AFTER: begin
            tgt = m + CNT_W'(1);
            if (list_empty)     dec_status = olt_pkg::ST_EMPTY;
            else if (!found)    dec_status = olt_pkg::ST_NOKEY;
            else if (list_full) dec_status = olt_pkg::ST_FULL;
            else                edit.op    = olt_pkg::EDIT_INS;
         end
         olt_pkg::CMD_INS_BEFORE: begin
            tgt = m;
            if (list_empty)     dec_status = olt_pkg::ST_EMPTY;
            else if (!found)    dec_status = olt_pkg::ST_NOKEY;
            else if (list_full) dec_status = olt_pkg::ST_FULL;
            else                edit.op    = olt_pkg::EDIT_INS;
         end
         olt_pkg::CMD_DEL_AFTER: begin
            tgt = m + CNT_W'(1);
            if (list_empty)            dec_status = olt_pkg::ST_EMPTY;
            else if (!found)           dec_status = olt_pkg::ST_NOKEY;
            else if (tgt >= count_ff)  dec_status = olt_pkg::ST_NONB;
            else                       edit.op    = olt_pkg::EDIT_DEL;
         end
         olt_pkg::CMD_DEL_BEFORE: begin
            tgt = m - CNT_W'(1);
            if (list_empty)    dec_status = olt_pkg::ST_EMPTY;
            else if (!found)   dec_status = olt_pkg::ST_NOKEY;
            else if (m == '0)  dec_status = olt_pkg::ST_NONB;
            else               edit.op    = olt_pkg::EDIT_DEL;
         end
         default: begin
            tgt = '0;
         end
      endcase

      // edits only land in the decide cycle, and only when the response can go
      if (state_ff != olt_pkg::ST_DECIDE || !rsp_load) edit.op = olt_pkg::EDIT_NONE;
      edit.idx = IDX_W'(tgt);

      case (edit.op)
         olt_pkg::EDIT_INS: dec_count = count_ff + CNT_W'(1);
         olt_pkg::EDIT_DEL: dec_count = count_ff - CNT_W'(1);
         default:           dec_count = count_ff;
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      logic [CNT_W-1:0] rd_idx;

      rd_idx       = '0;
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      count_in     = dec_count;
      rd_ptr_in    = rd_ptr_ff;
      head_hit_in  = head_hit_ff;
      tail_hit_in  = tail_hit_ff;
      mid_hit_in   = mid_hit_ff;
      req_chan.ready = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      data_in      = data_ff;
      index_in     = index_ff;
      rcount_in    = rcount_ff;
      last_in      = last_ff;

      case (state_ff)
         olt_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_fire) begin
               cmd_in    = olt_pkg::cmd_type'(req_chan.cmd);
               pos_in    = req_chan.position;
               key_in    = req_chan.key;
               value_in  = req_chan.value;
               rd_ptr_in = '0;
               if (req_chan.cmd == olt_pkg::CMD_READ_FWD ||
                   req_chan.cmd == olt_pkg::CMD_READ_REV) begin
                  state_in = olt_pkg::ST_READ;
               end else begin
                  state_in = olt_pkg::ST_MATCH;
               end
            end
         end
         olt_pkg::ST_MATCH: begin
            head_hit_in = cell_hit[0];
            tail_hit_in = |(cell_hit & tail_sel);
            mid_hit_in  = cell_hit & mid_range;
            state_in    = olt_pkg::ST_DECIDE;
         end
         olt_pkg::ST_DECIDE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               status_in    = dec_status;
               data_in      = '0;
               index_in     = '0;
               rcount_in    = olt_pkg::COUNT_W'(dec_count);
               last_in      = 1'b1;
               state_in     = olt_pkg::ST_IDLE;
            end
         end
         olt_pkg::ST_READ: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rcount_in    = olt_pkg::COUNT_W'(count_ff);
               if (list_empty) begin
                  status_in = olt_pkg::ST_EMPTY;
                  data_in   = '0;
                  index_in  = '0;
                  last_in   = 1'b1;
                  state_in  = olt_pkg::ST_IDLE;
               end else begin
                  if (cmd_ff == olt_pkg::CMD_READ_FWD) rd_idx = CNT_W'(rd_ptr_ff);
                  else rd_idx = count_ff - CNT_W'(1) - CNT_W'(rd_ptr_ff);
                  status_in = olt_pkg::ST_OK;
                  data_in   = cell_data[IDX_W'(rd_idx)];
                  index_in  = olt_pkg::INDEX_W'(rd_idx);
                  last_in   = (CNT_W'(rd_ptr_ff) == count_ff - CNT_W'(1));
                  rd_ptr_in = rd_ptr_ff + IDX_W'(1);
                  if (last_in) state_in = olt_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = olt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      rd_ptr_ff   <= rd_ptr_in;
      head_hit_ff <= head_hit_in;
      tail_hit_ff <= tail_hit_in;
      mid_hit_ff  <= mid_hit_in;
      status_ff   <= status_in;
      data_ff     <= data_in;
      index_ff    <= index_in;
      rcount_ff   <= rcount_in;
      last_ff     <= last_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.data   = data_ff;
   assign rsp_chan.index  = index_ff;
   assign rsp_chan.count  = rcount_ff;
   assign rsp_chan.last   = last_ff;

   // ---------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_count_moves_in_decide: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> $past(state_ff) == olt_pkg::ST_DECIDE)
      else $error("entry count changed outside the decide step");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == olt_pkg::ST_FULL) |->
         rcount_ff == olt_pkg::COUNT_W'(DEPTH))
      else $error("full status reported on a list with room");

   a_data_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && data_ff != '0) |-> status_ff == olt_pkg::ST_OK)
      else $error("nonzero data on a failed transaction");

endmodule

// ===== dv/tb_ordered_list_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_table_core
// Self-checking bench for the ordered list table. A queue-fed driver offers
// commands, a scoreboard list predicts the responses of every accepted
// command, and a monitor compares each response field by field. Directed
// corner cases come first, then filling to capacity and random edit/read
// traffic under varying sender and receiver throttling.
// ----------------------------------------------------------------------------
module tb_ordered_list_table_core;

   localparam int RSP_HOLD_CYCLES = 200;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int SETTLE_CYCLES   = 20;

   typedef struct {
      olt_pkg::cmd_type                  cmd;
      logic [olt_pkg::POS_W-1:0]         position;
      logic signed [olt_pkg::DATA_W-1:0] key;
      logic signed [olt_pkg::DATA_W-1:0] value;
   } list_cmd_type;

   typedef struct {
      olt_pkg::status_type               status;
      logic signed [olt_pkg::DATA_W-1:0] data;
      logic [olt_pkg::INDEX_W-1:0]       index;
      logic [olt_pkg::COUNT_W-1:0]       count;
      logic                              last;
   } list_rsp_type;

   logic clock;
   logic reset;

   olt_req_if req_chan ();
   olt_rsp_if rsp_chan ();

   ordered_list_table_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   list_cmd_type                      cmd_backlog[$];
   list_rsp_type                      rsp_due[$];
   logic signed [olt_pkg::DATA_W-1:0] list_vals[$];
   list_cmd_type                      drv_item;
   int                                send_idle_pct;
   int                                recv_idle_pct;
   logic                              rsp_hold_req;
   int                                rsp_hold_left;
   int                                quiet_cycles;
   int                                error_count;

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // --- scoreboard list ----------------------------------------------------

   function automatic olt_pkg::status_type insert_entry(int idx,
                                                        logic signed [olt_pkg::DATA_W-1:0] v);
      if (list_vals.size() >= olt_pkg::DEPTH) return olt_pkg::ST_FULL;
      list_vals.insert(idx, v);
      return olt_pkg::ST_OK;
   endfunction

   function automatic olt_pkg::status_type remove_entry(int idx);
      list_vals.delete(idx);
      return olt_pkg::ST_OK;
   endfunction

   function automatic void apply_list_command(list_cmd_type c);
      list_rsp_type        r;
      olt_pkg::status_type st;
      int                  n;
      int                  m;
      int                  idx;
      n = list_vals.size();
      r.data  = '0;
      r.index = '0;
      r.last  = 1'b1;
      if (c.cmd == olt_pkg::CMD_READ_FWD || c.cmd == olt_pkg::CMD_READ_REV) begin
         if (n == 0) begin
            r.status = olt_pkg::ST_EMPTY;
            r.count  = '0;
            rsp_due.push_back(r);
         end else begin
            for (int k = 0; k < n; k++) begin
               idx = (c.cmd == olt_pkg::CMD_READ_FWD) ? k : n - 1 - k;
               r.status = olt_pkg::ST_OK;
               r.data   = list_vals[idx];
               r.index  = olt_pkg::INDEX_W'(idx);
               r.count  = olt_pkg::COUNT_W'(n);
               r.last   = (k == n - 1);
               rsp_due.push_back(r);
            end
         end
         return;
      end
      if (c.cmd == olt_pkg::CMD_INS_POS) begin
         if (c.position < 1 || c.position > n + 1) st = olt_pkg::ST_BADPOS;
         else st = insert_entry(c.position - 1, c.value);
      end else if (c.cmd == olt_pkg::CMD_DEL_POS) begin
         if (n == 0) st = olt_pkg::ST_EMPTY;
         else if (c.position < 1 || c.position > n) st = olt_pkg::ST_BADPOS;
         else st = remove_entry(c.position - 1);
      end else if (n == 0) begin
         st = olt_pkg::ST_EMPTY;
      end else begin
         // head wins, then tail, then the first hit from the second entry on
         m = -1;
         if (list_vals[0] == c.key) m = 0;
         else if (list_vals[n-1] == c.key) m = n - 1;
         else begin
            for (int i = 1; i < n - 1; i++) begin
               if (m < 0 && list_vals[i] == c.key) m = i;
            end
         end
         if (m < 0) st = olt_pkg::ST_NOKEY;
         else begin
            case (c.cmd)
               olt_pkg::CMD_INS_AFTER:  st = insert_entry(m + 1, c.value);
               olt_pkg::CMD_INS_BEFORE: st = insert_entry(m, c.value);
               olt_pkg::CMD_DEL_AFTER:
                  st = (m + 1 >= n) ? olt_pkg::ST_NONB : remove_entry(m + 1);
               default:
                  st = (m == 0) ? olt_pkg::ST_NONB : remove_entry(m - 1);
            endcase
         end
      end
      r.status = st;
      r.count  = olt_pkg::COUNT_W'(list_vals.size());
      rsp_due.push_back(r);
   endfunction

   function automatic void check_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // --- driver -------------------------------------------------------------

   always @(posedge clock) begin : drive_proc
      logic offer;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) apply_list_command(drv_item);
         if (!req_chan.valid || req_chan.ready) begin
            offer = (cmd_backlog.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (offer) begin
               drv_item = cmd_backlog.pop_front();
               req_chan.cmd      <= drv_item.cmd;
               req_chan.position <= drv_item.position;
               req_chan.key      <= drv_item.key;
               req_chan.value    <= drv_item.value;
            end
            req_chan.valid <= offer;
         end
      end
   end

   // --- monitor ------------------------------------------------------------

   always @(posedge clock) begin : monitor_proc
      list_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (rsp_due.size() == 0) begin
               $error("response transaction with nothing expected (status %0d)",
                      rsp_chan.status);
               error_count++;
            end else begin
               want = rsp_due.pop_front();
               check_field("status", want.status, rsp_chan.status);
               check_field("data", want.data, rsp_chan.data);
               check_field("index", want.index, rsp_chan.index);
               check_field("count", want.count, rsp_chan.count);
               check_field("last", want.last, rsp_chan.last);
            end
         end
         if (rsp_hold_req && rsp_hold_left == 0) begin
            rsp_hold_left = RSP_HOLD_CYCLES;
            rsp_hold_req  = 1'b0;
         end
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // --- watchdog -----------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // --- stimulus -----------------------------------------------------------

   task automatic push_cmd(olt_pkg::cmd_type cmd, int pos,
                           logic signed [olt_pkg::DATA_W-1:0] key,
                           logic signed [olt_pkg::DATA_W-1:0] value);
      list_cmd_type c;
      c.cmd      = cmd;
      c.position = olt_pkg::POS_W'(pos);
      c.key      = key;
      c.value    = value;
      cmd_backlog.push_back(c);
   endtask

   // mostly a small pool so keys hit and duplicates show up
   function automatic logic signed [olt_pkg::DATA_W-1:0] pick_word(int raw_pct);
      if ($urandom_range(99) < raw_pct) return $urandom();
      case ($urandom_range(5))
         0:       return 32'sh0000_0000;
         1:       return 32'sh0000_0001;
         2:       return 32'shffff_ffff;
         3:       return 32'sh7fff_ffff;
         4:       return 32'sh8000_0000;
         default: return 32'sh0000_5a5a;
      endcase
   endfunction

   function automatic list_cmd_type random_command(int ins_w, int del_w);
      list_cmd_type c;
      int           roll;
      int           pos_roll;
      roll     = $urandom_range(99);
      pos_roll = $urandom_range(99);
      c.key    = pick_word(15);
      c.value  = pick_word(20);
      if (pos_roll < 45) c.position = olt_pkg::POS_W'($urandom_range(4, 1));
      else if (pos_roll < 80) c.position = olt_pkg::POS_W'($urandom_range(33, 1));
      else c.position = olt_pkg::POS_W'($urandom_range(33, 0));
      if (roll < ins_w) begin
         case ($urandom_range(3))
            0, 1:    c.cmd = olt_pkg::CMD_INS_POS;
            2:       c.cmd = olt_pkg::CMD_INS_AFTER;
            default: c.cmd = olt_pkg::CMD_INS_BEFORE;
         endcase
      end else if (roll < ins_w + del_w) begin
         case ($urandom_range(3))
            0, 1:    c.cmd = olt_pkg::CMD_DEL_POS;
            2:       c.cmd = olt_pkg::CMD_DEL_AFTER;
            default: c.cmd = olt_pkg::CMD_DEL_BEFORE;
         endcase
      end else if ($urandom_range(1) == 0) begin
         c.cmd = olt_pkg::CMD_READ_FWD;
      end else begin
         c.cmd = olt_pkg::CMD_READ_REV;
      end
      return c;
   endfunction

   task automatic queue_random(int n, int ins_w, int del_w);
      repeat (n) cmd_backlog.push_back(random_command(ins_w, del_w));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_chan.valid || rsp_due.size() != 0);
   endtask

   initial begin : stimulus
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.cmd      = olt_pkg::CMD_READ_FWD;
      req_chan.position = '0;
      req_chan.key      = '0;
      req_chan.value    = '0;
      rsp_chan.ready    = 1'b0;
      rsp_hold_req      = 1'b0;
      rsp_hold_left     = 0;
      quiet_cycles      = 0;
      error_count       = 0;
      send_idle_pct     = 37;
      recv_idle_pct     = 64;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list: everything but a positional insert at position 1 is refused
      push_cmd(olt_pkg::CMD_READ_FWD, 0, 0, 0);
      push_cmd(olt_pkg::CMD_READ_REV, 0, 0, 0);
      push_cmd(olt_pkg::CMD_INS_AFTER, 0, 0, 0);
      push_cmd(olt_pkg::CMD_INS_BEFORE, 0, 0, 0);
      push_cmd(olt_pkg::CMD_DEL_POS, 1, 0, 0);
      push_cmd(olt_pkg::CMD_DEL_AFTER, 0, 0, 0);
      push_cmd(olt_pkg::CMD_DEL_BEFORE, 0, 0, 0);
      push_cmd(olt_pkg::CMD_INS_POS, 0, 0, 0);
      push_cmd(olt_pkg::CMD_INS_POS, 2, 0, 0);
      push_cmd(olt_pkg::CMD_INS_POS, 1, 0, 32'sh8000_0000);
      // single entry is both head and tail: no neighbour either way
      push_cmd(olt_pkg::CMD_DEL_AFTER, 0, 32'sh8000_0000, 0);
      push_cmd(olt_pkg::CMD_DEL_BEFORE, 0, 32'sh8000_0000, 0);
      push_cmd(olt_pkg::CMD_INS_POS, 2, 0, 32'sh7fff_ffff);
      push_cmd(olt_pkg::CMD_INS_AFTER, 0, 32'sh7fff_ffff, 32'sh0000_0000);
      push_cmd(olt_pkg::CMD_INS_BEFORE, 0, 32'sh8000_0000, 32'shffff_ffff);
      push_cmd(olt_pkg::CMD_INS_AFTER, 0, 32'sh0000_3039, 5);
      push_cmd(olt_pkg::CMD_DEL_AFTER, 0, 32'sh0000_0000, 0);
      push_cmd(olt_pkg::CMD_READ_FWD, 0, 0, 0);
      push_cmd(olt_pkg::CMD_READ_REV, 0, 0, 0);
      push_cmd(olt_pkg::CMD_DEL_POS, 0, 0, 0);
      push_cmd(olt_pkg::CMD_DEL_POS, 5, 0, 0);
      push_cmd(olt_pkg::CMD_DEL_BEFORE, 0, 32'sh0000_0000, 0);
      push_cmd(olt_pkg::CMD_DEL_AFTER, 0, 32'shffff_ffff, 0);
      push_cmd(olt_pkg::CMD_DEL_POS, 2, 0, 0);
      push_cmd(olt_pkg::CMD_DEL_POS, 1, 0, 0);
      wait_drained();

      // list is empty again: fill to capacity at valid positions, then probe full
      for (int k = 0; k < olt_pkg::DEPTH; k++)
         push_cmd(olt_pkg::CMD_INS_POS, $urandom_range(k + 1, 1), 0, pick_word(20));
      push_cmd(olt_pkg::CMD_INS_POS, 33, 0, pick_word(20));
      push_cmd(olt_pkg::CMD_INS_POS, 0, 0, pick_word(20));
      push_cmd(olt_pkg::CMD_INS_AFTER, 0, $urandom(), pick_word(20));
      push_cmd(olt_pkg::CMD_INS_BEFORE, 0, pick_word(0), pick_word(20));
      push_cmd(olt_pkg::CMD_INS_AFTER, 0, pick_word(0), pick_word(20));
      push_cmd(olt_pkg::CMD_READ_FWD, 0, 0, 0);
      push_cmd(olt_pkg::CMD_READ_REV, 0, 0, 0);
      push_cmd(olt_pkg::CMD_DEL_POS, 33, 0, 0);
      push_cmd(olt_pkg::CMD_DEL_POS, 32, 0, 0);

      // grow-biased traffic; the receiver holds off for a long stretch meanwhile
      queue_random(80, 65, 25);
      rsp_hold_req = 1'b1;
      wait_drained();

      send_idle_pct = 64;
      recv_idle_pct = 37;
      queue_random(60, 45, 45);
      queue_random(60, 15, 75);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(45, 60, 30);
      queue_random(45, 40, 50);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && rsp_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
